/* rtl/ctpp_pkg.sv */
// Shared types, constants and helpers for the tile chunky-to-planar packer.
`default_nettype none

package ctpp_pkg;

   // Tile geometry and plane image layout
   localparam int TILE_WIDTH      = 16;
   localparam int TILE_HEIGHT     = 16;
   localparam int TILES_PER_ROW   = 20;
   localparam int PALETTE_ENTRIES = 32;
   localparam int MAX_TILES       = 1024;
   localparam int ROW_BYTES       = 40;

   // Field widths
   localparam int RGB_W      = 24;
   localparam int TILE_NUM_W = 10;
   localparam int POS_W      = 4;
   localparam int OFFSET_W   = 16;
   localparam int PEN_W      = 8;
   localparam int MAX_PLANES = 8;
   localparam int PLANE_W    = $clog2(MAX_PLANES);
   localparam int REM_W      = $clog2(TILES_PER_ROW + 1);

   // Tile divided by tiles per row: floor reciprocal, one correction step
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (1 << RECIP_SHIFT) / TILES_PER_ROW;

   // Configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_COUNT   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLORS_IN_USE = 1'b1;
   localparam logic [3:0] PLANE_COUNT_RESET   = 4'd4;
   localparam logic [5:0] COLORS_IN_USE_RESET = 6'd16;

   // Request and response codes
   localparam logic MODE_PALETTE = 1'b0;
   localparam logic MODE_PIXEL   = 1'b1;
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_ERROR   = 1'b1;

   // Pen remap for the first sixteen palette indices
   localparam logic [3:0] PEN_TABLE [16] = '{
      4'd12, 4'd0, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd8,
      4'd9, 4'd10, 4'd11, 4'd13, 4'd15, 4'd14, 4'd1, 4'd6
   };

   typedef struct packed {
      logic       mode;
      logic [4:0] palette_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [TILE_NUM_W-1:0] tile_number;
      logic [POS_W-1:0] pixel_row;
      logic [POS_W-1:0] pixel_column;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [PLANE_W-1:0] plane;
      logic [OFFSET_W-1:0] byte_offset;
      logic [7:0] byte_value;
      logic       last;
      logic [TILE_NUM_W-1:0] bad_tile;
      logic [POS_W-1:0] bad_row;
      logic [POS_W-1:0] bad_column;
   } rsp_type;

   // Accumulator memory control
   typedef struct packed {
      logic rd_en;
      logic [PLANE_W-1:0] rd_addr;
      logic wr_en;
      logic [PLANE_W-1:0] wr_addr;
      logic [7:0] wr_data;
      logic clear;
   } acc_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_ERROR,
      ST_PL_READ,
      ST_PL_WRITE
   } state_type;

   // Map a matched palette index to its pen
   function automatic logic [PEN_W-1:0] pen_of(input logic [PEN_W-1:0] idx);
      logic [PEN_W-1:0] pen;
      if (idx < PEN_W'(16)) begin
         pen = {4'b0, PEN_TABLE[idx[3:0]]};
      end else begin
         pen = idx;
      end
      return pen;
   endfunction

endpackage

`default_nettype wire

/* rtl/ctpp_palette.sv */
// Palette store: one write port, one registered read port.
`default_nettype none

module ctpp_palette #(
   parameter int ENTRIES = ctpp_pkg::PALETTE_ENTRIES
) (
   input  wire logic clock,
   input  wire logic wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  wire logic [ctpp_pkg::RGB_W-1:0] wr_data,
   input  wire logic rd_en,
   input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [ctpp_pkg::RGB_W-1:0] rd_data
);

   logic [ctpp_pkg::RGB_W-1:0] mem [ENTRIES];
   logic [ctpp_pkg::RGB_W-1:0] rd_data_ff;

   // Write a loaded entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/ctpp_accum.sv */
// Plane accumulator memory with per-entry valid bits; invalid entries read as zero.
`default_nettype none

module ctpp_accum (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ctpp_pkg::acc_ctl_type ctl,
   output logic [7:0] rd_data
);

   logic [7:0] mem [ctpp_pkg::MAX_PLANES];
   logic [ctpp_pkg::MAX_PLANES-1:0] valid_ff;
   logic [7:0] rd_mem_ff;
   logic rd_valid_ff;

   // Write the modified byte back
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   // Track written entries, drop them all on clear
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_mem_ff   <= mem[ctl.rd_addr];
         rd_valid_ff <= valid_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : 8'd0;

   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(ctl.rd_en && ctl.wr_en && (ctl.rd_addr == ctl.wr_addr)))
      else $error("accumulator read and write hit the same entry");

   a_no_clear_with_write: assert property (@(posedge clock) disable iff (reset)
      !(ctl.clear && ctl.wr_en))
      else $error("accumulator clear collides with a write");

endmodule

`default_nettype wire

/* rtl/tile_chunky_to_planar_packer.sv */
// Top level of the tile chunky-to-planar packer.
// Palette load request: accepted while idle, no response.
// Pixel request: palette search over up to min(colors_in_use, 32) entries (one
// palette memory read per cycle), then an accumulator read and write for each plane.
// Unmatched pixel: one error response once the search finds no match.
// Reset clears control, config to defaults and all accumulators; palette is undefined until loaded.
`default_nettype none

module tile_chunky_to_planar_packer #(
   parameter int PALETTE_ENTRIES = ctpp_pkg::PALETTE_ENTRIES
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire ctpp_pkg::req_type req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output ctpp_pkg::rsp_type rsp_data,
   input  wire logic csr_write_en,
   input  wire logic [ctpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ctpp_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int IW = $clog2(PALETTE_ENTRIES);
   localparam int CW = $clog2(PALETTE_ENTRIES + 1);

   ctpp_pkg::state_type state_ff, state_in;
   ctpp_pkg::req_type req_ff;
   ctpp_pkg::rsp_type rsp_data_ff, rsp_next;
   ctpp_pkg::acc_ctl_type acc_ctl;

   logic [3:0] plane_count_ff;
   logic [5:0] colors_ff;
   logic supp_ff;
   logic [ctpp_pkg::TILE_NUM_W-1:0] supp_tile_ff;
   logic [CW-1:0] rd_addr_ff;
   logic [CW-1:0] n_cnt;
   logic pend_ff;
   logic [IW-1:0] pend_idx_ff;
   logic [ctpp_pkg::PEN_W-1:0] pen_ff;
   logic [ctpp_pkg::PLANE_W-1:0] plane_ff;
   logic [ctpp_pkg::PLANE_W-1:0] planes_m1;
   logic rsp_valid_ff, rsp_load;

   logic pal_wr_en, pal_rd_en;
   logic [ctpp_pkg::RGB_W-1:0] pal_rdata, pix_rgb;
   logic [7:0] acc_rdata, new_acc;

   logic accept, in_range, start, hit, miss, emit, last_plane, out_free, advance;
   logic [2:0] pos;

   logic [ctpp_pkg::TILE_NUM_W-1:0] q1_ff, q_ff, q_in;
   logic [ctpp_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [ctpp_pkg::OFFSET_W-1:0] offset_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= ctpp_pkg::PLANE_COUNT_RESET;
         colors_ff      <= ctpp_pkg::COLORS_IN_USE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ctpp_pkg::CSR_PLANE_COUNT: begin
               plane_count_ff <= csr_write_data[3:0];
            end
            ctpp_pkg::CSR_COLORS_IN_USE: begin
               colors_ff <= csr_write_data[5:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp plane count and color count
   always_comb begin
      if (plane_count_ff == 4'd0) begin
         planes_m1 = '0;
      end else if (plane_count_ff > 4'(ctpp_pkg::MAX_PLANES)) begin
         planes_m1 = ctpp_pkg::PLANE_W'(ctpp_pkg::MAX_PLANES - 1);
      end else begin
         planes_m1 = ctpp_pkg::PLANE_W'(plane_count_ff - 4'd1);
      end
      if (int'(colors_ff) > PALETTE_ENTRIES) begin
         n_cnt = CW'(PALETTE_ENTRIES);
      end else begin
         n_cnt = CW'(colors_ff);
      end
   end

   // Request decode
   assign accept   = req_valid && !req_stall;
   assign in_range = (int'(req_data.pixel_row) < ctpp_pkg::TILE_HEIGHT)
                  && (int'(req_data.pixel_column) < ctpp_pkg::TILE_WIDTH)
                  && (int'(req_data.tile_number) < ctpp_pkg::MAX_TILES);
   assign start    = accept && (req_data.mode == ctpp_pkg::MODE_PIXEL) && in_range
                  && !(supp_ff && (req_data.tile_number == supp_tile_ff));
   assign pal_wr_en = accept && (req_data.mode == ctpp_pkg::MODE_PALETTE)
                   && (int'(req_data.palette_index) < PALETTE_ENTRIES);

   // Search and plane update conditions
   assign pix_rgb    = {req_ff.red, req_ff.green, req_ff.blue};
   assign hit        = (state_ff == ctpp_pkg::ST_SEARCH) && pend_ff && (pal_rdata == pix_rgb);
   assign miss       = (state_ff == ctpp_pkg::ST_SEARCH) && !hit && (rd_addr_ff >= n_cnt);
   assign pos        = req_ff.pixel_column[2:0];
   assign emit       = (pos == 3'd7)
                    || (int'(req_ff.pixel_column) == ctpp_pkg::TILE_WIDTH - 1);
   assign last_plane = (plane_ff == planes_m1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = !emit || out_free;
   assign new_acc    = {acc_rdata[6:0], pen_ff[plane_ff]};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctpp_pkg::ST_IDLE: begin
            if (start) begin
               state_in = ctpp_pkg::ST_SEARCH;
            end
         end
         ctpp_pkg::ST_SEARCH: begin
            if (hit) begin
               state_in = ctpp_pkg::ST_PL_READ;
            end else if (miss) begin
               state_in = ctpp_pkg::ST_ERROR;
            end
         end
         ctpp_pkg::ST_ERROR: begin
            if (out_free) begin
               state_in = ctpp_pkg::ST_IDLE;
            end
         end
         ctpp_pkg::ST_PL_READ: begin
            state_in = ctpp_pkg::ST_PL_WRITE;
         end
         ctpp_pkg::ST_PL_WRITE: begin
            if (advance) begin
               state_in = last_plane ? ctpp_pkg::ST_IDLE : ctpp_pkg::ST_PL_READ;
            end
         end
         default: begin
            state_in = ctpp_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      pal_rd_en = 1'b0;
      acc_ctl   = '0;
      rsp_load  = 1'b0;
      rsp_next  = '0;
      case (state_ff)
         ctpp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         ctpp_pkg::ST_SEARCH: begin
            pal_rd_en = (rd_addr_ff < n_cnt);
         end
         ctpp_pkg::ST_ERROR: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_next.kind       = ctpp_pkg::KIND_ERROR;
               rsp_next.last       = 1'b1;
               rsp_next.bad_tile   = req_ff.tile_number;
               rsp_next.bad_row    = req_ff.pixel_row;
               rsp_next.bad_column = req_ff.pixel_column;
               acc_ctl.clear       = 1'b1;
            end
         end
         ctpp_pkg::ST_PL_READ: begin
            acc_ctl.rd_en   = 1'b1;
            acc_ctl.rd_addr = plane_ff;
         end
         ctpp_pkg::ST_PL_WRITE: begin
            if (emit) begin
               if (out_free) begin
                  rsp_load             = 1'b1;
                  rsp_next.kind        = ctpp_pkg::KIND_BYTE;
                  rsp_next.plane       = plane_ff;
                  rsp_next.byte_offset = offset_ff;
                  rsp_next.byte_value  = new_acc << (3'd7 - pos);
                  rsp_next.last        = last_plane;
                  acc_ctl.clear        = last_plane;
               end
            end else begin
               acc_ctl.wr_en   = 1'b1;
               acc_ctl.wr_addr = plane_ff;
               acc_ctl.wr_data = new_acc;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctpp_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         supp_ff      <= 1'b0;
         supp_tile_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pal_rd_en;
         // End suppression on a pixel of another tile, start it on a miss
         if (start && supp_ff) begin
            supp_ff <= 1'b0;
         end else if ((state_ff == ctpp_pkg::ST_ERROR) && out_free) begin
            supp_ff      <= 1'b1;
            supp_tile_ff <= req_ff.tile_number;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture, search pointer, pen and plane counter
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (start) begin
         rd_addr_ff <= '0;
      end else if (pal_rd_en) begin
         rd_addr_ff <= rd_addr_ff + CW'(1);
      end
      if (pal_rd_en) begin
         pend_idx_ff <= rd_addr_ff[IW-1:0];
      end
      if (hit) begin
         pen_ff   <= ctpp_pkg::pen_of(ctpp_pkg::PEN_W'(pend_idx_ff));
         plane_ff <= '0;
      end else if ((state_ff == ctpp_pkg::ST_PL_WRITE) && advance) begin
         plane_ff <= plane_ff + ctpp_pkg::PLANE_W'(1);
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // Correct the reciprocal quotient of tile by tiles per row
   always_comb begin
      int prod;
      int rem_raw;
      prod    = int'(q1_ff) * ctpp_pkg::TILES_PER_ROW;
      rem_raw = int'(req_ff.tile_number) - prod;
      if (rem_raw >= ctpp_pkg::TILES_PER_ROW) begin
         q_in   = q1_ff + ctpp_pkg::TILE_NUM_W'(1);
         rem_in = ctpp_pkg::REM_W'(rem_raw - ctpp_pkg::TILES_PER_ROW);
      end else begin
         q_in   = q1_ff;
         rem_in = ctpp_pkg::REM_W'(rem_raw);
      end
   end

   // Offset pipeline: q1_ff, then q_ff and rem_ff, then offset_ff
   always_ff @(posedge clock) begin
      q1_ff  <= ctpp_pkg::TILE_NUM_W'((int'(req_ff.tile_number) * ctpp_pkg::RECIP)
                                      >> ctpp_pkg::RECIP_SHIFT);
      q_ff   <= q_in;
      rem_ff <= rem_in;
      offset_ff <= ctpp_pkg::OFFSET_W'(
         int'(q_ff) * (ctpp_pkg::TILE_HEIGHT * ctpp_pkg::ROW_BYTES)
         + int'(rem_ff) * (ctpp_pkg::TILE_WIDTH / 8)
         + int'(req_ff.pixel_row) * ctpp_pkg::ROW_BYTES
         + int'(req_ff.pixel_column >> 3));
   end

   ctpp_palette #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (IW'(req_data.palette_index)),
      .wr_data ({req_data.red, req_data.green, req_data.blue}),
      .rd_en   (pal_rd_en),
      .rd_addr (rd_addr_ff[IW-1:0]),
      .rd_data (pal_rdata)
   );

   ctpp_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .rd_data (acc_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response register overwritten while held");

   a_hit_within_colors: assert property (@(posedge clock) disable iff (reset)
      hit |-> (CW'(pend_idx_ff) < n_cnt))
      else $error("palette match outside the colors in use");

   a_palette_port: assert property (@(posedge clock) disable iff (reset)
      !(pal_wr_en && pal_rd_en))
      else $error("palette load during search");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the tile chunky-to-planar packer.
`timescale 1ns / 100ps

module tb_top;
   import ctpp_pkg::*;

   localparam int SETTLE_CYCLES = 100;
   localparam int IDLE_PERCENT  = 7;

   // Pen remap of the first sixteen palette indices
   localparam logic [3:0] PEN_MAP [16] = '{
      4'd12, 4'd0, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd8,
      4'd9, 4'd10, 4'd11, 4'd13, 4'd15, 4'd14, 4'd1, 4'd6
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   tile_chunky_to_planar_packer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Requests waiting to be driven and plane writes waiting to be seen
   req_type pending_reqs[$];
   rsp_type expected_writes[$];

   // Predictor state
   logic [23:0] palette_shadow [PALETTE_ENTRIES];
   logic [7:0]  plane_acc [MAX_PLANES] = '{default: 8'd0};
   logic        suppress_on = 1'b0;
   logic [TILE_NUM_W-1:0] suppress_tile = '0;
   logic [3:0]  plane_shadow = PLANE_COUNT_RESET;
   logic [5:0]  colors_shadow = COLORS_IN_USE_RESET;

   // Generator view of the palette as queued so far
   logic [23:0] palette_plan [PALETTE_ENTRIES];
   int match_limit = 16;

   logic req_done = 1'b0;
   int   req_count = 0;
   int   mismatch_count = 0;
   logic quiet;

   // No idling on either side while this window of requests goes through
   assign quiet = (req_count >= 70) && (req_count < 120);

   // Work out the plane writes or the error that one request causes
   function automatic void predict_planes(input req_type r);
      logic [23:0] rgb;
      logic [7:0]  pen;
      int match, n, planes, pos, offset;
      rsp_type w;
      rgb = {r.red, r.green, r.blue};
      if (r.mode == MODE_PALETTE) begin
         palette_shadow[r.palette_index] = rgb;
         return;
      end
      if (suppress_on) begin
         if (r.tile_number == suppress_tile) return;
         suppress_on = 1'b0;
      end
      n = (colors_shadow > PALETTE_ENTRIES) ? PALETTE_ENTRIES : colors_shadow;
      match = -1;
      for (int i = 0; i < n; i++) begin
         if (match < 0 && palette_shadow[i] == rgb) match = i;
      end
      if (match < 0) begin
         for (int k = 0; k < MAX_PLANES; k++) plane_acc[k] = 8'd0;
         suppress_on = 1'b1;
         suppress_tile = r.tile_number;
         w = '0;
         w.kind = KIND_ERROR;
         w.last = 1'b1;
         w.bad_tile = r.tile_number;
         w.bad_row = r.pixel_row;
         w.bad_column = r.pixel_column;
         expected_writes.push_back(w);
         return;
      end
      pen = (match < 16) ? {4'b0, PEN_MAP[match]} : 8'(match);
      planes = (plane_shadow < 1) ? 1 : (plane_shadow > MAX_PLANES) ? MAX_PLANES
             : plane_shadow;
      for (int k = 0; k < planes; k++) plane_acc[k] = {plane_acc[k][6:0], pen[k]};
      pos = r.pixel_column % 8;
      if (pos != 7 && r.pixel_column != TILE_WIDTH - 1) return;
      offset = (r.tile_number / TILES_PER_ROW) * TILE_HEIGHT * ROW_BYTES
             + (r.tile_number % TILES_PER_ROW) * (TILE_WIDTH / 8)
             + r.pixel_row * ROW_BYTES + r.pixel_column / 8;
      for (int k = 0; k < planes; k++) begin
         w = '0;
         w.kind = KIND_BYTE;
         w.plane = PLANE_W'(k);
         w.byte_offset = offset[15:0];
         w.byte_value = 8'(plane_acc[k] << (7 - pos));
         w.last = (k == planes - 1);
         expected_writes.push_back(w);
      end
      for (int k = 0; k < MAX_PLANES; k++) plane_acc[k] = 8'd0;
   endfunction

   // Compare one response with the oldest expectation
   task automatic check_write(input rsp_type got, input rsp_type want);
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, got.kind);
         mismatch_count++;
      end
      if (got.plane !== want.plane) begin
         $error("plane: expected %0d, got %0d", want.plane, got.plane);
         mismatch_count++;
      end
      if (got.byte_offset !== want.byte_offset) begin
         $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
         mismatch_count++;
      end
      if (got.byte_value !== want.byte_value) begin
         $error("byte_value: expected %02h, got %02h", want.byte_value, got.byte_value);
         mismatch_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         mismatch_count++;
      end
      if (got.bad_tile !== want.bad_tile) begin
         $error("bad_tile: expected %0d, got %0d", want.bad_tile, got.bad_tile);
         mismatch_count++;
      end
      if (got.bad_row !== want.bad_row) begin
         $error("bad_row: expected %0d, got %0d", want.bad_row, got.bad_row);
         mismatch_count++;
      end
      if (got.bad_column !== want.bad_column) begin
         $error("bad_column: expected %0d, got %0d", want.bad_column, got.bad_column);
         mismatch_count++;
      end
   endtask

   // Monitor: check responses first, then predict for the accepted request
   always @(posedge clock) begin
      req_done <= req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            $error("unexpected response: kind %0d plane %0d offset %0d",
                   rsp_data.kind, rsp_data.plane, rsp_data.byte_offset);
            mismatch_count++;
         end else begin
            check_write(rsp_data, expected_writes.pop_front());
         end
      end
      if (!reset && req_valid && !req_stall) begin
         predict_planes(req_data);
         req_count++;
      end
   end

   // Driver: advance to the next request once the current one is taken
   always @(negedge clock) begin
      if (!req_valid || req_done) begin
         if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   task automatic queue_load(input int idx, input logic [23:0] rgb);
      req_type r;
      r = req_type'({$urandom, $urandom});
      r.mode = MODE_PALETTE;
      r.palette_index = 5'(idx);
      {r.red, r.green, r.blue} = rgb;
      palette_plan[idx] = rgb;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_pixel(input int tile, input int row, input int col,
                              input logic [23:0] rgb);
      req_type r;
      r = req_type'({$urandom, $urandom});
      r.mode = MODE_PIXEL;
      {r.red, r.green, r.blue} = rgb;
      r.tile_number = TILE_NUM_W'(tile);
      r.pixel_row = POS_W'(row);
      r.pixel_column = POS_W'(col);
      pending_reqs.push_back(r);
   endtask

   // A colour that none of the active palette entries holds
   function automatic logic [23:0] unmatched_color();
      logic [23:0] c;
      bit hit;
      do begin
         c = 24'($urandom);
         hit = 1'b0;
         for (int i = 0; i < match_limit; i++) begin
            if (palette_plan[i] == c) hit = 1'b1;
         end
      end while (hit);
      return c;
   endfunction

   // Mostly an active palette colour, now and then an unmatched one
   function automatic logic [23:0] pick_color();
      if (match_limit == 0 || $urandom_range(0, 99) < 4) return unmatched_color();
      return palette_plan[$urandom_range(0, match_limit - 1)];
   endfunction

   // Random part: mostly ordered column runs, plus reloads, strays and cut runs
   task automatic queue_random(input int count);
      int made, roll, tile, row, first, len;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         tile = $urandom_range(0, MAX_TILES - 1);
         row = $urandom_range(0, TILE_HEIGHT - 1);
         first = 8 * $urandom_range(0, 1);
         if (roll < 65) begin
            len = (first == 0 && $urandom_range(0, 1)) ? 16 : 8;
            for (int c = first; c < first + len; c++) queue_pixel(tile, row, c, pick_color());
            made += len;
         end else if (roll < 75) begin
            queue_load($urandom_range(0, PALETTE_ENTRIES - 1), 24'($urandom));
            made++;
         end else if (roll < 90) begin
            queue_pixel(tile, row, $urandom_range(0, TILE_WIDTH - 1), pick_color());
            made++;
         end else begin
            len = $urandom_range(1, 7);
            for (int c = first; c < first + len; c++) queue_pixel(tile, row, c, pick_color());
            made += len;
         end
      end
   endtask

   // Wait until every request is taken and every response seen, then let the block settle
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_DATA_W'(value);
      @(posedge clock);
      if (idx == CSR_PLANE_COUNT) plane_shadow = 4'(value);
      else colors_shadow = 6'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(input int planes, input int colors);
      drain();
      write_csr(CSR_PLANE_COUNT, planes);
      write_csr(CSR_COLORS_IN_USE, colors);
      match_limit = (colors > PALETTE_ENTRIES) ? PALETTE_ENTRIES : colors;
   endtask

   // Hold reset, then run the directed part and the random phases
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Active palette at reset settings: black first, white last
      queue_load(0, 24'h000000);
      for (int i = 1; i < 15; i++) queue_load(i, 24'($urandom));
      queue_load(15, 24'hFFFFFF);

      // Left group of the first tile, right group of the last tile
      for (int c = 0; c < 8; c++) queue_pixel(0, 0, c, palette_plan[c]);
      for (int c = 8; c < 16; c++) queue_pixel(MAX_TILES - 1, 15, c, palette_plan[c]);
      // Unmatched colour, a suppressed pixel of that tile, then another tile resumes
      queue_pixel(5, 3, 2, unmatched_color());
      queue_pixel(5, 3, 3, palette_plan[0]);
      queue_pixel(6, 0, 15, palette_plan[12]);
      // Out-of-order columns: a stray bit, then the end of a group
      queue_pixel(2, 1, 12, palette_plan[4]);
      queue_pixel(2, 1, 7, palette_plan[9]);

      // All planes, all entries; duplicate colours test first-match priority
      configure(8, 32);
      for (int i = 16; i < 31; i++) queue_load(i, 24'($urandom));
      queue_load(20, palette_plan[3]);
      queue_load(31, 24'hFFFFFF);
      queue_random(25);

      configure(1, 1);
      queue_random(10);

      // Plane count zero acts as one; colour count beyond the palette saturates
      configure(0, 63);
      queue_random(15);

      // No active colours: every pixel that is not suppressed is an error; plane count above eight
      configure(15, 0);
      queue_random(6);

      configure(5, 24);
      queue_random(20);

      drain();
      if (mismatch_count == 0 && expected_writes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* tile_chunky_to_planar_packer.f */
rtl/ctpp_pkg.sv
rtl/ctpp_palette.sv
rtl/ctpp_accum.sv
rtl/tile_chunky_to_planar_packer.sv
verif/tb_top.sv
